[design/scd_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the
// sine column displacement block. No dependencies.
package scd_pkg;

  localparam int MAX_WIDTH        = 256;
  localparam int MAX_HEIGHT       = 128;
  localparam int SINE_TABLE_DEPTH = 256;

  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int PIXEL_W     = 32;
  localparam int COL_W       = 8;
  localparam int ROW_W       = 7;
  localparam int OFFSET_W    = 9;
  localparam int SRC_W       = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_START  = 3'd4;

  localparam logic [8:0] FRAME_WIDTH_RESET  = 9'd128;
  localparam logic [7:0] FRAME_HEIGHT_RESET = 8'd64;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic [15:0]        column_phase_step;
    logic [15:0]        phase_start;
  } wave_cfg_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_tab_t [SINE_TABLE_DEPTH];

  // sin(pi/2 * (i + 1/2) / depth) in unsigned Q0.15, Taylor series in Q30
  function automatic logic [14:0] sine_entry(int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = HALF_PI_Q30 * longint'(2 * i + 1) / (2 * SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  function automatic sine_tab_t sine_table_build();
    sine_tab_t t;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TABLE = sine_table_build();

endpackage

[design/scd_channels.sv]
// Valid/ready channel interfaces for pixel requests and results.
// Depends on scd_pkg for field widths.
interface scd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [scd_pkg::COL_W-1:0]   column;
  logic [scd_pkg::ROW_W-1:0]   row;
  logic [scd_pkg::PIXEL_W-1:0] pixel_in;

  modport source (output valid, kind, column, row, pixel_in, input ready);
  modport sink   (input valid, kind, column, row, pixel_in, output ready);
endinterface

interface scd_out_if;
  logic                        valid;
  logic                        ready;
  logic [scd_pkg::PIXEL_W-1:0] pixel_out;
  logic                        from_source;
  logic                        bad_coordinate;

  modport source (output valid, pixel_out, from_source, bad_coordinate, input ready);
  modport sink   (input valid, pixel_out, from_source, bad_coordinate, output ready);
endinterface

[design/scd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module scd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/scd_wave.sv]
// Column offset pipeline: phase, sine lookup, amplitude multiply, rounding.
// Depends on scd_pkg for the sine table and the wave configuration struct.
module scd_wave (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [scd_pkg::COL_W-1:0]            column,
  input  scd_pkg::wave_cfg_t                   cfg,
  output logic                                 done,
  output logic signed [scd_pkg::OFFSET_W-1:0]  offset
);

  localparam int PROD_W = 14 + scd_pkg::IDX_W + 1;

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [15:0] phase_r;
  logic [14:0] smag_r;
  logic        neg2_r, neg3_r;
  logic [31:0] prod_r;

  logic [23:0]               col_prod;
  logic [PROD_W-1:0]         idx_scaled;
  logic [PROD_W-1:0]         idx_raw;
  logic [scd_pkg::IDX_W-1:0] idx;
  logic [scd_pkg::IDX_W-1:0] idx_sel;
  logic [16:0]               amp_ext;
  logic [16:0]               amag;
  logic [31:0]               rounded;
  logic [scd_pkg::OFFSET_W-1:0] mag;

  always_comb begin
    col_prod   = 24'(column) * 24'(cfg.column_phase_step);
    idx_scaled = PROD_W'(phase_r[13:0]) * PROD_W'(scd_pkg::SINE_TABLE_DEPTH);
    idx_raw    = idx_scaled >> 14;
    if (idx_raw > PROD_W'(scd_pkg::SINE_TABLE_DEPTH - 1)) begin
      idx = scd_pkg::IDX_W'(scd_pkg::SINE_TABLE_DEPTH - 1);
    end else begin
      idx = idx_raw[scd_pkg::IDX_W-1:0];
    end
    if (phase_r[14]) begin
      idx_sel = scd_pkg::IDX_W'(scd_pkg::SINE_TABLE_DEPTH - 1) - idx;
    end else begin
      idx_sel = idx;
    end
    amp_ext = {cfg.amplitude[15], cfg.amplitude};
    amag    = cfg.amplitude[15] ? (17'd0 - amp_ext) : amp_ext;
    rounded = (prod_r + (32'd1 << 22)) >> 23;
    mag     = rounded[scd_pkg::OFFSET_W-1:0];
  end

  // column is registered by the caller on start, so the pipe runs behind start by that column register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= cfg.phase_start + col_prod[15:0];
    smag_r  <= scd_pkg::SINE_TABLE[idx_sel];
    neg2_r  <= phase_r[15] ^ cfg.amplitude[15];
    prod_r  <= 32'(amag) * 32'(smag_r);
    neg3_r  <= neg2_r;
  end

  assign done   = v4_r;
  assign offset = neg3_r ? -$signed(mag) : $signed(mag);

endmodule

[design/sine_column_displacement.sv]
// Sine column displacement top level: configuration, sequencer, frame store.
// Depends on scd_pkg, scd_channels (interfaces), scd_ram and scd_wave.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, column, row, pixel_in
//   out_ch   out  valid/ready   pixel_out, from_source, bad_coordinate
//   cfg_*    in   write enable  cfg_index, cfg_data
//
// A write is stored in its accept cycle. A read passes the accept cycle, the
// offset pipeline, a frame store read and the output register load; a read
// with a bad coordinate skips the pipeline and the read. Reset is synchronous,
// active low, and needs no clearing pass. A stalled result sits in the output
// register while the next request is accepted; a read result waits there for it.
module sine_column_displacement (
  input  logic                              clk,
  input  logic                              rst_n,
  scd_in_if.sink                            in_ch,
  scd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  scd_pkg::state_t   state_r, state_nxt;
  logic [8:0]        frame_width_r;
  logic [7:0]        frame_height_r;
  scd_pkg::wave_cfg_t wave_cfg_r;

  logic [scd_pkg::COL_W-1:0]   column_r;
  logic [scd_pkg::ROW_W-1:0]   row_r;
  logic                        bad_r;
  logic                        hit_r;
  logic                        out_valid_r;
  logic [scd_pkg::PIXEL_W-1:0] pixel_out_r;
  logic                        from_source_r;
  logic                        bad_out_r;

  logic                              in_acc;
  logic                              bad_in;
  logic                              ram_we;
  logic                              ram_re;
  logic                              wave_start;
  logic                              wave_done;
  logic                              load_out;
  logic signed [scd_pkg::OFFSET_W-1:0] offset;
  logic signed [scd_pkg::SRC_W-1:0]    src_row;
  logic                              src_ok;
  logic [scd_pkg::ADDR_W-1:0]        waddr;
  logic [scd_pkg::ADDR_W-1:0]        raddr;
  logic [scd_pkg::PIXEL_W-1:0]       rdata;

  function automatic logic [scd_pkg::ADDR_W-1:0] frame_addr(logic [8:0] r, logic [7:0] c);
    return scd_pkg::ADDR_W'(r) * scd_pkg::ADDR_W'(scd_pkg::MAX_WIDTH) +
           scd_pkg::ADDR_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= scd_pkg::FRAME_WIDTH_RESET;
      frame_height_r <= scd_pkg::FRAME_HEIGHT_RESET;
      wave_cfg_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scd_pkg::CFG_FRAME_WIDTH:  frame_width_r <= cfg_data[8:0];
        scd_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[7:0];
        scd_pkg::CFG_AMPLITUDE:    wave_cfg_r.amplitude <= $signed(cfg_data);
        scd_pkg::CFG_PHASE_STEP:   wave_cfg_r.column_phase_step <= cfg_data;
        scd_pkg::CFG_PHASE_START:  wave_cfg_r.phase_start <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    bad_in = ({1'b0, in_ch.column} >= frame_width_r) ||
             (32'(in_ch.column) >= scd_pkg::MAX_WIDTH) ||
             ({1'b0, in_ch.row} >= frame_height_r) ||
             (32'(in_ch.row) >= scd_pkg::MAX_HEIGHT);
    src_row = $signed({3'b000, row_r}) - $signed({offset[scd_pkg::OFFSET_W-1], offset});
    src_ok  = !src_row[scd_pkg::SRC_W-1] &&
              (src_row[8:0] < {1'b0, frame_height_r}) &&
              (32'(src_row[8:0]) < scd_pkg::MAX_HEIGHT);
    waddr   = frame_addr({2'b00, in_ch.row}, in_ch.column);
    raddr   = frame_addr(src_row[8:0], column_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scd_pkg::ST_IDLE: begin
        if (in_acc && in_ch.kind == scd_pkg::KIND_READ) begin
          state_nxt = bad_in ? scd_pkg::ST_RESP : scd_pkg::ST_WAVE;
        end
      end
      scd_pkg::ST_WAVE: begin
        if (wave_done) begin
          state_nxt = scd_pkg::ST_RESP;
        end
      end
      scd_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = scd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    wave_start  = 1'b0;
    ram_re      = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      scd_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_we      = in_acc && in_ch.kind == scd_pkg::KIND_WRITE && !bad_in;
        wave_start  = in_acc && in_ch.kind == scd_pkg::KIND_READ && !bad_in;
      end
      scd_pkg::ST_WAVE: begin
        ram_re = wave_done && src_ok;
      end
      scd_pkg::ST_RESP: begin
        load_out = !out_valid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      column_r <= in_ch.column;
      row_r    <= in_ch.row;
      bad_r    <= bad_in;
      hit_r    <= 1'b0;
    end
    if (state_r == scd_pkg::ST_WAVE && wave_done) begin
      hit_r <= src_ok;
    end
    if (load_out) begin
      pixel_out_r   <= hit_r ? rdata : '0;
      from_source_r <= hit_r;
      bad_out_r     <= bad_r;
    end
  end

  scd_wave u_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (wave_start),
    .column (column_r),
    .cfg    (wave_cfg_r),
    .done   (wave_done),
    .offset (offset)
  );

  scd_ram #(
    .WIDTH (scd_pkg::PIXEL_W),
    .DEPTH (scd_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_ch.pixel_in),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pixel_out      = pixel_out_r;
  assign out_ch.from_source    = from_source_r;
  assign out_ch.bad_coordinate = bad_out_r;

endmodule

[bench/tb_sine_column_displacement.sv]
`timescale 1ns / 1ps
// Testbench for sine_column_displacement: pixel write/read requests with a frame-store
// and sine-offset predictor, random idling on both channels. Depends on scd_pkg, scd_channels.
module tb_sine_column_displacement;

  typedef struct packed {
    logic [31:0] pixel;
    logic        from_src;
    logic        bad;
  } pix_result_t;

  typedef enum logic [1:0] {OP_WR, OP_RD, OP_CFG} plan_op_t;

  typedef struct packed {
    plan_op_t                      op;
    logic [scd_pkg::CFG_IDX_W-1:0] reg_sel;
    logic [31:0]                   data;
    logic [7:0]                    col;
    logic [6:0]                    row;
    logic                          typed;
    pix_result_t                   res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data;

  scd_in_if  in_ch ();
  scd_out_if out_ch ();

  sine_column_displacement u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // register mirror
  logic [8:0]  fw;
  logic [7:0]  fh;
  logic [15:0] wave_amp;
  logic [15:0] wave_step;
  logic [15:0] wave_start;

  int unsigned  sine_lut [scd_pkg::SINE_TABLE_DEPTH];
  logic [31:0]  src_pixels [scd_pkg::FRAME_DEPTH];
  bit           src_written [scd_pkg::FRAME_DEPTH];
  pix_result_t  due_pixels [$];
  pix_result_t  got;
  pix_result_t  want;

  int errors = 0;
  bit calm = 1'b0;
  int src_pct = 0;
  int sink_pct = 0;
  int sink_hold = 0;

  plan_row_t opening_plan [28] = '{
    '{OP_WR,  '0, 32'hFFFF_FFFF, 8'd0,   7'd0,   1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd0,   1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{OP_WR,  '0, 32'h5A5A_A5A5, 8'd127, 7'd63,  1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd127, 7'd63,  1'b1, '{32'h5A5A_A5A5, 1'b1, 1'b0}},
    '{OP_WR,  '0, 32'h1234_5678, 8'd128, 7'd0,   1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd128, 7'd0,   1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd64,  1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_RD,  '0, 32'h0,         8'd255, 7'd127, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_CFG, scd_pkg::CFG_PHASE_START,  32'h4000, 8'd0, 7'd0, 1'b0, '0},
    '{OP_CFG, scd_pkg::CFG_AMPLITUDE,    32'h7FFF, 8'd0, 7'd0, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd63,  1'b1, '{32'h0, 1'b0, 1'b0}},
    '{OP_CFG, scd_pkg::CFG_AMPLITUDE,    32'h8000, 8'd0, 7'd0, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd0,   1'b1, '{32'h0, 1'b0, 1'b0}},
    '{OP_CFG, scd_pkg::CFG_AMPLITUDE,    32'h0100, 8'd0, 7'd0, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd1,   1'b0, '0},
    '{OP_WR,  '0, 32'h0000_0001, 8'd0,   7'd1,   1'b0, '0},
    '{OP_CFG, scd_pkg::CFG_PHASE_START,  32'hC000, 8'd0, 7'd0, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd0,   1'b0, '0},
    '{OP_CFG, scd_pkg::CFG_FRAME_WIDTH,  32'h0,    8'd0, 7'd0, 1'b0, '0},
    '{OP_WR,  '0, 32'hDEAD_BEEF, 8'd0,   7'd0,   1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd0,   7'd0,   1'b1, '{32'h0, 1'b0, 1'b1}},
    '{OP_CFG, scd_pkg::CFG_FRAME_WIDTH,  32'h1FF,  8'd0, 7'd0, 1'b0, '0},
    '{OP_CFG, scd_pkg::CFG_FRAME_HEIGHT, 32'hFF,   8'd0, 7'd0, 1'b0, '0},
    '{OP_CFG, scd_pkg::CFG_AMPLITUDE,    32'h0,    8'd0, 7'd0, 1'b0, '0},
    '{OP_WR,  '0, 32'hC3C3_C3C3, 8'd255, 7'd127, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd255, 7'd127, 1'b1, '{32'hC3C3_C3C3, 1'b1, 1'b0}},
    '{OP_CFG, scd_pkg::CFG_FRAME_HEIGHT, 32'h0,    8'd0, 7'd0, 1'b0, '0},
    '{OP_RD,  '0, 32'h0,         8'd5,   7'd0,   1'b1, '{32'h0, 1'b0, 1'b1}}
  };

  function automatic int span_w();
    return (fw > scd_pkg::MAX_WIDTH) ? scd_pkg::MAX_WIDTH : int'(fw);
  endfunction

  function automatic int span_h();
    return (fh > scd_pkg::MAX_HEIGHT) ? scd_pkg::MAX_HEIGHT : int'(fh);
  endfunction

  function automatic bit off_frame(logic [7:0] c, logic [6:0] r);
    return int'(c) >= span_w() || int'(r) >= span_h();
  endfunction

  // signed row offset of column c, half away from zero
  function automatic int wave_offset(logic [7:0] c);
    logic [15:0] ph;
    int          idx;
    int          smag;
    int          amag;
    longint      prod;
    int          mag;
    ph   = wave_start + c * wave_step;
    idx  = (int'(ph[13:0]) * scd_pkg::SINE_TABLE_DEPTH) >> 14;
    smag = ph[14] ? sine_lut[scd_pkg::SINE_TABLE_DEPTH-1-idx] : sine_lut[idx];
    amag = wave_amp[15] ? 65536 - int'(wave_amp) : int'(wave_amp);
    prod = longint'(amag) * smag;
    mag  = int'((prod + (64'd1 << 22)) >> 23);
    return (wave_amp[15] ^ ph[15]) ? -mag : mag;
  endfunction

  task automatic model_request(logic k, logic [7:0] c, logic [6:0] r, logic [31:0] p);
    int          src;
    pix_result_t res;
    if (k == scd_pkg::KIND_WRITE) begin
      if (!off_frame(c, r)) begin
        src_pixels[int'(r) * scd_pkg::MAX_WIDTH + c]  = p;
        src_written[int'(r) * scd_pkg::MAX_WIDTH + c] = 1'b1;
      end
    end else begin
      res = '{32'h0, 1'b0, off_frame(c, r)};
      if (!res.bad) begin
        src = int'(r) - wave_offset(c);
        if (src >= 0 && src < span_h()) begin
          res.pixel    = src_pixels[src * scd_pkg::MAX_WIDTH + c];
          res.from_src = 1'b1;
        end
      end
      due_pixels.push_back(res);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic put_req(logic k, logic [7:0] c, logic [6:0] r, logic [31:0] p);
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.kind     = k;
    in_ch.column   = c;
    in_ch.row      = r;
    in_ch.pixel_in = p;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic issue(logic k, logic [7:0] c, logic [6:0] r, logic [31:0] p);
    put_req(k, c, r, p);
    model_request(k, c, r, p);
  endtask

  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 99) < src_pct) begin
      n = $urandom_range(1, 14);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [scd_pkg::CFG_IDX_W-1:0] sel, logic [15:0] val);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = sel;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (sel)
      scd_pkg::CFG_FRAME_WIDTH:  fw         = val[8:0];
      scd_pkg::CFG_FRAME_HEIGHT: fh         = val[7:0];
      scd_pkg::CFG_AMPLITUDE:    wave_amp   = val;
      scd_pkg::CFG_PHASE_STEP:   wave_step  = val;
      scd_pkg::CFG_PHASE_START:  wave_start = val;
      default: ;
    endcase
  endtask

  // mostly in-frame requests; a read whose source pixel was never stored gets it stored first
  task automatic random_request(inout int made);
    int         w;
    int         h;
    int         pick;
    int         src;
    logic [7:0] c;
    logic [6:0] r;
    logic       k;
    w    = span_w();
    h    = span_h();
    pick = $urandom_range(0, 99);
    if (pick < 80 && w > 0 && h > 0) begin
      c = 8'($urandom_range(0, w - 1));
      r = 7'($urandom_range(0, h - 1));
      k = (pick < 35) ? scd_pkg::KIND_WRITE : scd_pkg::KIND_READ;
    end else begin
      c = 8'($urandom);
      r = 7'($urandom);
      k = 1'($urandom);
    end
    if (k == scd_pkg::KIND_READ && !off_frame(c, r)) begin
      src = int'(r) - wave_offset(c);
      if (src >= 0 && src < h && !src_written[src * scd_pkg::MAX_WIDTH + c]) begin
        sender_gap();
        issue(scd_pkg::KIND_WRITE, c, 7'(src), $urandom);
        made++;
      end
    end
    made++;
    sender_gap();
    issue(k, c, r, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_pixels.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = due_pixels.pop_front();
        got  = '{out_ch.pixel_out, out_ch.from_source, out_ch.bad_coordinate};
        if (got.pixel !== want.pixel)
          report_mismatch($sformatf("pixel_out %h, want %h", got.pixel, want.pixel));
        if (got.from_src !== want.from_src)
          report_mismatch($sformatf("from_source %b, want %b", got.from_src, want.from_src));
        if (got.bad !== want.bad)
          report_mismatch($sformatf("bad_coordinate %b, want %b", got.bad, want.bad));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold--;
      end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
        sink_hold = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #1_500_000;
    $display("tb_sine_column_displacement: errors");
    $finish;
  end

  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned v;
    plan_row_t       pr;
    int              made;
    int              sel;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = scd_pkg::CFG_FRAME_WIDTH;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = scd_pkg::KIND_WRITE;
    in_ch.column   = '0;
    in_ch.row      = '0;
    in_ch.pixel_in = '0;
    fw         = scd_pkg::FRAME_WIDTH_RESET;
    fh         = scd_pkg::FRAME_HEIGHT_RESET;
    wave_amp   = '0;
    wave_step  = '0;
    wave_start = '0;

    // quarter sine at bin centers, Taylor series in Q30
    for (int i = 0; i < scd_pkg::SINE_TABLE_DEPTH; i++) begin
      x    = scd_pkg::HALF_PI_Q30 * 64'(2 * i + 1) / 64'(2 * scd_pkg::SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      v = (64'(acc) * 64'd32768 + (64'd1 << 29)) >> 30;
      sine_lut[i] = (v > 64'd32767) ? 32767 : int'(v);
    end

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    src_pct  = 20;
    sink_pct = 20;
    foreach (opening_plan[i]) begin
      pr = opening_plan[i];
      if (pr.op == OP_CFG) begin
        set_reg(pr.reg_sel, pr.data[15:0]);
      end else begin
        sender_gap();
        if (pr.typed) begin
          put_req(scd_pkg::KIND_READ, pr.col, pr.row, pr.data);
          due_pixels.push_back(pr.res);
        end else begin
          issue(pr.op == OP_RD ? scd_pkg::KIND_READ : scd_pkg::KIND_WRITE,
                pr.col, pr.row, pr.data);
        end
      end
    end

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase == 7);
      case ($urandom_range(0, 2))
        0: src_pct = 0;
        1: src_pct = 15;
        default: src_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: sink_pct = 0;
        1: sink_pct = 15;
        default: sink_pct = 50;
      endcase
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        set_reg(scd_pkg::CFG_FRAME_WIDTH, 16'($urandom_range(0, 511)));
        set_reg(scd_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(0, 255)));
      end else if (sel < 3) begin
        set_reg(scd_pkg::CFG_FRAME_WIDTH, 16'(scd_pkg::MAX_WIDTH));
        set_reg(scd_pkg::CFG_FRAME_HEIGHT, 16'(scd_pkg::MAX_HEIGHT));
      end else begin
        set_reg(scd_pkg::CFG_FRAME_WIDTH, 16'($urandom_range(1, 40)));
        set_reg(scd_pkg::CFG_FRAME_HEIGHT, 16'($urandom_range(1, 24)));
      end
      case ($urandom_range(0, 3))
        0: set_reg(scd_pkg::CFG_AMPLITUDE, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
        1: set_reg(scd_pkg::CFG_AMPLITUDE, 16'($urandom));
        default: set_reg(scd_pkg::CFG_AMPLITUDE, 16'($urandom_range(0, 2048) - 1024));
      endcase
      set_reg(scd_pkg::CFG_PHASE_STEP, 16'($urandom));
      set_reg(scd_pkg::CFG_PHASE_START, 16'($urandom));
      made = 0;
      while (made < 230) random_request(made);
    end

    settle();
    if (errors == 0) begin
      $display("tb_sine_column_displacement: clean");
    end else begin
      $display("tb_sine_column_displacement: errors");
    end
    $finish;
  end

endmodule
